@@ src/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, idle while reset is held
`define DMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// concurrent check on the rising clock, also active during reset
`define DMA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/dma_pkg.sv @@
// ----------------------------------------------------------------------------
// dma_pkg
// Types and constants of the dual moving average sensor block.
// ----------------------------------------------------------------------------
package dma_pkg;

    // window depth, a power of two so the mean is an arithmetic shift
    localparam int WINDOW_SIZE = 8;
    localparam int WIN_LOG2    = $clog2(WINDOW_SIZE);

    // field widths
    localparam int TEMP_W = 12;
    localparam int HUM_W  = 10;
    localparam int CNT_W  = 16;

    // running sum widths, wide enough for a full window
    localparam int TSUM_W = TEMP_W + WIN_LOG2;
    localparam int HSUM_W = HUM_W + WIN_LOG2;

    // warm-up register reset and tick counter ceiling
    localparam logic [CNT_W-1:0] WARMUP_RESET = CNT_W'(2000);
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    // input item kind
    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_READING = 1'b1
    } t_kind;

    // input item
    typedef struct packed {
        t_kind                    kind;
        logic signed [TEMP_W-1:0] temp_sample;
        logic        [HUM_W-1:0]  hum_sample;
        logic                     temp_ok;
        logic                     hum_ok;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [TEMP_W-1:0] avg_temp;
        logic        [HUM_W-1:0]  avg_hum;
        logic                     has_values;
        logic                     warmed_up;
    } t_out_item;

    // one window entry, held by one cell
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic        [HUM_W-1:0]  hum;
    } t_entry;

    // cell control
    typedef struct packed {
        logic fill;
        logic shift;
    } t_cell_ctrl;

    // result queue status
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

@@ src/dma_cell.sv @@
// ----------------------------------------------------------------------------
// dma_cell
// One window entry. Loads the new reading on fill, or takes its upstream
// neighbor's entry on shift, so the last cell of the row is the oldest entry.
// ----------------------------------------------------------------------------
module dma_cell
    import dma_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_prev,
    output t_entry     o_entry
);

    t_entry r_entry;

    // payload only, no reset: every cell is written by the first fill
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill) begin
            r_entry <= i_new;
        end else if (i_ctrl.shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ src/dma_outq.sv @@
// ----------------------------------------------------------------------------
// dma_outq
// Two-entry result queue. Decouples the output stall from input acceptance
// so a new item is taken while one finished result waits.
// ----------------------------------------------------------------------------
module dma_outq
    import dma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    input  logic      i_stall,
    output t_q_stat   o_stat,
    output t_out_item o_data
);

    t_out_item  r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    logic       w_pop;
    logic [1:0] n_count;

    // pop when the head is shown and not stalled
    assign w_pop = (r_count != 2'd0) && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.valid = (r_count != 2'd0);
    assign o_data       = r_buf[r_rd];

endmodule

@@ src/dual_moving_average_sensor.sv @@
// ----------------------------------------------------------------------------
// dual_moving_average_sensor
// Boxcar moving average of paired temperature and humidity readings, with
// a tick-counted warm-up after reset and a row of window cells.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  input     i_in_valid, o_in_stall, i_in_item    item in, valid/stall
//  output    o_out_valid, i_out_stall, o_out_item item out, valid/stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data warmup_ticks write
//
//  one item per cycle while not stalled: the running sums take one add and one subtract,
//  the mean is a shift, and the result is queued in the next cycle
//  the two-entry result queue holds input stall low until both entries wait
//  reset is synchronous; window cells hold no reset and are filled by the
//  first accepted reading
// ----------------------------------------------------------------------------
module dual_moving_average_sensor
    import dma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    // control state
    logic [CNT_W-1:0]         r_warmup_ticks;
    logic [CNT_W-1:0]         r_count;
    logic                     r_started;
    logic                     r_primed;
    logic signed [TSUM_W-1:0] r_tsum;
    logic        [HSUM_W-1:0] r_hsum;
    logic signed [TEMP_W-1:0] r_avg_temp;
    logic        [HUM_W-1:0]  r_avg_hum;

    logic [CNT_W-1:0]         n_count;
    logic                     n_started;
    logic                     n_primed;
    logic signed [TSUM_W-1:0] n_tsum;
    logic        [HSUM_W-1:0] n_hsum;
    logic signed [TEMP_W-1:0] n_avg_temp;
    logic        [HUM_W-1:0]  n_avg_hum;

    logic       w_accept;
    logic       w_take;
    t_cell_ctrl w_ctrl;
    t_entry     w_new;
    t_entry     w_chain [WINDOW_SIZE];
    t_entry     w_oldest;
    t_out_item  w_result;
    t_q_stat    w_qstat;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // warm-up counting and start flag
    always_comb begin
        n_count = r_count;
        if (i_in_item.kind == KIND_TICK && !r_started && r_count != CNT_MAX) begin
            n_count = r_count + CNT_W'(1);
        end
        n_started = r_started || (n_count >= r_warmup_ticks);
    end

    // reading is used once started and both values valid
    assign w_take = (i_in_item.kind == KIND_READING) && n_started
                    && i_in_item.temp_ok && i_in_item.hum_ok;

    assign w_new.temp   = i_in_item.temp_sample;
    assign w_new.hum    = i_in_item.hum_sample;
    assign w_ctrl.fill  = w_accept && w_take && !r_primed;
    assign w_ctrl.shift = w_accept && w_take && r_primed;
    assign w_oldest     = w_chain[WINDOW_SIZE-1];

    // window row: cell 0 takes the new reading, the last cell is the oldest
    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        if (g == 0) begin : g_head
            dma_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_new   (w_new),
                .i_prev  (w_new),
                .o_entry (w_chain[g])
            );
        end else begin : g_body
            dma_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_new   (w_new),
                .i_prev  (w_chain[g-1]),
                .o_entry (w_chain[g])
            );
        end
    end

    // running sums: prime fills the window, later readings replace the oldest
    always_comb begin
        n_primed   = r_primed;
        n_tsum     = r_tsum;
        n_hsum     = r_hsum;
        n_avg_temp = r_avg_temp;
        n_avg_hum  = r_avg_hum;
        if (w_take) begin
            n_primed = 1'b1;
            if (!r_primed) begin
                n_tsum = {i_in_item.temp_sample, {WIN_LOG2{1'b0}}};
                n_hsum = {i_in_item.hum_sample, {WIN_LOG2{1'b0}}};
            end else begin
                n_tsum = r_tsum
                         - {{WIN_LOG2{w_oldest.temp[TEMP_W-1]}}, w_oldest.temp}
                         + {{WIN_LOG2{i_in_item.temp_sample[TEMP_W-1]}},
                            i_in_item.temp_sample};
                n_hsum = r_hsum
                         - {{WIN_LOG2{1'b0}}, w_oldest.hum}
                         + {{WIN_LOG2{1'b0}}, i_in_item.hum_sample};
            end
            // mean by shift, floor for negative sums
            n_avg_temp = n_tsum[TSUM_W-1:WIN_LOG2];
            n_avg_hum  = n_hsum[HSUM_W-1:WIN_LOG2];
        end
    end

    // state update on each accepted item, warm-up ticks on each config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_ticks <= WARMUP_RESET;
            r_count        <= '0;
            r_started      <= 1'b0;
            r_primed       <= 1'b0;
            r_tsum         <= '0;
            r_hsum         <= '0;
            r_avg_temp     <= '0;
            r_avg_hum      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_warmup_ticks <= i_cfg_data;
            end
            if (w_accept) begin
                r_count    <= n_count;
                r_started  <= n_started;
                r_primed   <= n_primed;
                r_tsum     <= n_tsum;
                r_hsum     <= n_hsum;
                r_avg_temp <= n_avg_temp;
                r_avg_hum  <= n_avg_hum;
            end
        end
    end

    // result of this item
    assign w_result.avg_temp   = n_avg_temp;
    assign w_result.avg_hum    = n_avg_hum;
    assign w_result.has_values = n_primed;
    assign w_result.warmed_up  = n_started;

    dma_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .i_stall (i_out_stall),
        .o_stat  (w_qstat),
        .o_data  (o_out_item)
    );

    assign o_in_stall  = w_qstat.full;
    assign o_out_valid = w_qstat.valid;

endmodule

@@ src/dma_checker.sv @@
// ----------------------------------------------------------------------------
// dma_checker
// Port-level checks of the dual moving average sensor, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dma_checker
    import dma_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in_item         i_in_item,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_item        o_out_item,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CNT_W-1:0] i_cfg_data
);

    // a stalled result stays shown and unchanged
    `DMA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "stalled result item changed")

    // once warmed up, later result items stay warmed up
    `DMA_ASSERT(a_warm_sticky, o_out_valid && o_out_item.warmed_up |=> !o_out_valid || o_out_item.warmed_up, "warmed_up fell")

    // once values exist, later result items keep them
    `DMA_ASSERT(a_values_sticky, o_out_valid && o_out_item.has_values |=> !o_out_valid || o_out_item.has_values, "has_values fell")

    // a reading is only taken after warm-up
    `DMA_ASSERT(a_values_need_warm, o_out_valid && o_out_item.has_values |-> o_out_item.warmed_up, "values without warm-up")

    // means stay zero before the first reading
    `DMA_ASSERT(a_zero_before_values, o_out_valid && !o_out_item.has_values |-> o_out_item.avg_temp == '0 && o_out_item.avg_hum == '0, "nonzero mean before first reading")

endmodule

bind dual_moving_average_sensor dma_checker u_dma_checker (.*);
